FILE: hdl/annealed_sign_gradient_seeker_assert.svh
// Assertion macros used by the seeker's top module.
`ifndef ANNEALED_SIGN_GRADIENT_SEEKER_ASSERT_SVH
`define ANNEALED_SIGN_GRADIENT_SEEKER_ASSERT_SVH

// cond holds at every clock edge out of reset
`define ASGS_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define ASGS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons holds in the cycle after ante
`define ASGS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/asgs_pkg.sv
package asgs_pkg;

   localparam int unsigned EPOCHS        = 50;
   localparam int unsigned POSITION_SPAN = 2048;

   localparam int unsigned SPAN_Q  = POSITION_SPAN * 256;
   localparam int unsigned POS_W   = $clog2(SPAN_Q);
   localparam int unsigned P_W     = $clog2(EPOCHS + 1);
   localparam int unsigned RATE_W  = 16;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned SUM_W   = 24;
   localparam int unsigned EPOCH_W = 8;
   localparam int unsigned OUT_POS_W = 19;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - OUT_POS_W - SAMPLE_W;

   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   // widest value that goes through span reduction: start position in Q11.8
   localparam int unsigned RED_W     = 19;
   localparam int unsigned RED_STEPS = $clog2((2 ** RED_W - 1) / SPAN_Q + 1);

   localparam int unsigned TABLE_LAST = 50;

   typedef logic [15:0] weight_type;
   typedef weight_type cos_rom_type [0:TABLE_LAST];
   typedef weight_type weight_lut_type [0:EPOCHS];
   typedef logic [POS_W-1:0] pos_type;

   // 0.5*(1+cos(pi*k/50)) in Q1.15
   localparam cos_rom_type COSINE_TABLE = '{
      16'd32768, 16'd32736, 16'd32639, 16'd32478, 16'd32253, 16'd31966, 16'd31617,
      16'd31209, 16'd30741, 16'd30217, 16'd29639, 16'd29008, 16'd28327, 16'd27600,
      16'd26828, 16'd26014, 16'd25163, 16'd24277, 16'd23360, 16'd22415, 16'd21447,
      16'd20459, 16'd19454, 16'd18437, 16'd17413, 16'd16384, 16'd15355, 16'd14331,
      16'd13314, 16'd12309, 16'd11321, 16'd10353, 16'd9408,  16'd8491,  16'd7605,
      16'd6754,  16'd5940,  16'd5168,  16'd4441,  16'd3760,  16'd3129,  16'd2551,
      16'd2027,  16'd1559,  16'd1151,  16'd802,   16'd515,   16'd290,   16'd129,
      16'd32,    16'd0
   };

   // weight per phase epoch, folded at elaboration
   function automatic weight_lut_type build_weights();
      weight_lut_type lut;
      for (int unsigned p = 0; p <= EPOCHS; p++) begin
         lut[p] = COSINE_TABLE[(p * TABLE_LAST) / EPOCHS];
      end
      return lut;
   endfunction

   localparam weight_lut_type WEIGHT_LUT = build_weights();

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_RUN   = 2'd2
   } phase_type;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_MEASURE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      REG_FIRST_HIGH  = 2'd0,
      REG_FIRST_LOW   = 2'd1,
      REG_SECOND_HIGH = 2'd2,
      REG_SECOND_LOW  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [RATE_W-1:0] first_high;
      logic [RATE_W-1:0] first_low;
      logic [RATE_W-1:0] second_high;
      logic [RATE_W-1:0] second_low;
   } rate_cfg_type;

   localparam rate_cfg_type RATE_CFG_RESET = '{
      first_high:  16'd12800,
      first_low:   16'd128,
      second_high: 16'd128,
      second_low:  16'd0
   };

   // v mod SPAN_Q by binary compare-subtract
   function automatic pos_type reduce_span(input logic [RED_W-1:0] v);
      logic [RED_W-1:0] acc;
      acc = v;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (32'(acc) >= (SPAN_Q << k)) begin
            acc = acc - RED_W'(SPAN_Q << k);
         end
      end
      return POS_W'(acc);
   endfunction

   function automatic pos_type move_position(input pos_type pos,
                                             input logic [RATE_W-1:0] mag,
                                             input logic neg);
      pos_type      m;
      logic [POS_W:0] s;
      m = reduce_span(RED_W'(mag));
      if (neg) begin
         s = ({1'b0, pos} + (POS_W + 1)'(SPAN_Q)) - {1'b0, m};
      end else begin
         s = {1'b0, pos} + {1'b0, m};
      end
      if (32'(s) >= SPAN_Q) begin
         s = s - (POS_W + 1)'(SPAN_Q);
      end
      return s[POS_W-1:0];
   endfunction

endpackage

FILE: hdl/asgs_csr.sv
module asgs_csr
   import asgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output rate_cfg_type          cfg
);

   rate_cfg_type  cfg_ff;
   rate_cfg_type  cfg_in;
   reg_index_type addr_idx;
   logic          wr_en;

   assign addr_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en    = psel & penable & pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (addr_idx)
            REG_FIRST_HIGH:  cfg_in.first_high  = pwdata[RATE_W-1:0];
            REG_FIRST_LOW:   cfg_in.first_low   = pwdata[RATE_W-1:0];
            REG_SECOND_HIGH: cfg_in.second_high = pwdata[RATE_W-1:0];
            REG_SECOND_LOW:  cfg_in.second_low  = pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (addr_idx)
         REG_FIRST_HIGH:  prdata = CSR_DATA_W'(cfg_ff.first_high);
         REG_FIRST_LOW:   prdata = CSR_DATA_W'(cfg_ff.first_low);
         REG_SECOND_HIGH: prdata = CSR_DATA_W'(cfg_ff.second_high);
         REG_SECOND_LOW:  prdata = CSR_DATA_W'(cfg_ff.second_low);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= RATE_CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/asgs_rate.sv
module asgs_rate
   import asgs_pkg::*;
(
   input  logic [EPOCH_W-1:0] epoch,
   input  rate_cfg_type       cfg,
   output logic [RATE_W-1:0]  rate
);

   logic              beyond;
   logic              second;
   logic [P_W-1:0]    p;
   logic [RATE_W-1:0] low;
   logic [RATE_W-1:0] high;
   logic              up;
   logic [RATE_W-1:0] diff;
   weight_type        w;
   logic [31:0]       rounded;
   logic [RATE_W-1:0] adj;

   assign beyond = epoch > EPOCH_W'(2 * EPOCHS);
   assign second = epoch > EPOCH_W'(EPOCHS);
   assign p      = second ? P_W'(epoch - EPOCH_W'(EPOCHS)) : P_W'(epoch);
   assign low    = second ? cfg.second_low  : cfg.first_low;
   assign high   = second ? cfg.second_high : cfg.first_high;
   assign up     = high >= low;
   assign diff   = up ? (high - low) : (low - high);
   assign w      = WEIGHT_LUT[p];

   // round half up, Q1.15 weight
   assign rounded = (32'(diff) * 32'(w)) + 32'd16384;
   assign adj     = rounded[30:15];

   always_comb begin
      if (beyond) begin
         rate = cfg.second_low;
      end else if (up) begin
         rate = low + adj;
      end else begin
         rate = low - adj;
      end
   end

endmodule

FILE: hdl/asgs_avg.sv
module asgs_avg
   import asgs_pkg::*;
(
   input  logic [SUM_W-1:0]    sum,
   output logic [SAMPLE_W-1:0] average
);

   // exact floor(sum / EPOCHS) by reciprocal multiply
   localparam int unsigned AVG_SHIFT = SUM_W + $clog2(EPOCHS);
   localparam int unsigned RECIP_W   = SUM_W + 2;
   localparam int unsigned PROD_W    = SUM_W + RECIP_W;
   localparam int unsigned Q_W       = PROD_W - AVG_SHIFT;
   localparam longint unsigned AVG_RECIP =
      ((64'd1 << AVG_SHIFT) + 64'(EPOCHS) - 64'd1) / 64'(EPOCHS);

   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    quot;

   assign prod = PROD_W'(sum) * PROD_W'(AVG_RECIP);
   assign quot = prod[PROD_W-1:AVG_SHIFT];

   assign average = (|quot[Q_W-1:SAMPLE_W]) ? '1 : quot[SAMPLE_W-1:0];

endmodule

FILE: hdl/annealed_sign_gradient_seeker.sv
// Annealed sign-gradient extremum seeker.
// req channel: one beat per command. tuser = command (0 start, 1 measurement);
// tdata carries start position and step for a start, the sample for a measurement.
// rsp channel: exactly one beat per req beat, in order: next position (Q11.8,
// modulo the span), third-phase mean and its valid flag.
// csr port: four 16-bit rate registers (Q8.8), written only while idle; the user
// must keep to that, the block itself does not enforce it.
// Throughput: one beat per cycle while rsp is not stalled; the seeker state updates in the
// cycle the beat moves from the input register to the result register, so consecutive
// beats see each other's updates with no bubble.
// Reset: rate registers take their defaults, position, step, epoch, sum and
// previous sample clear, and the seeker waits for a start.
// Stall: the result register holds while rsp_tready is low; one more req beat
// is held in the input register, after which req_tready drops.
`include "annealed_sign_gradient_seeker_assert.svh"

module annealed_sign_gradient_seeker
   import asgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // start_position, start_step, measured_value
   input  logic                  req_tuser,   // command

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // position, average_value, zero pad
   output logic                  rsp_tuser,   // average_valid

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   rate_cfg_type rate_cfg;
   logic [RATE_W-1:0] rate;
   logic [SAMPLE_W-1:0] avg_q;

   // input register
   logic                req_valid_ff, req_valid_in;
   command_type         cmd_ff;
   logic [10:0]         spos_ff;
   logic [4:0]          sstep_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   // seeker state
   pos_type             pos_ff, pos_in;
   logic [RATE_W-1:0]   mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   phase_type           phase_ff, phase_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_POS_W-1:0] rsp_pos_ff;
   logic [SAMPLE_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic                 rsp_avgv_ff, rsp_avgv_in;

   logic req_accept;
   logic advance;
   logic in_third;
   logic avg_due;
   logic reverse;

   asgs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (rate_cfg)
   );

   asgs_rate u_rate (
      .epoch (epoch_ff),
      .cfg   (rate_cfg),
      .rate  (rate)
   );

   asgs_avg u_avg (
      .sum     (sum_ff),
      .average (avg_q)
   );

   assign csr_pready = 1'b1;

   assign advance    = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   assign req_valid_in = req_accept | (req_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   assign in_third = (epoch_ff >= EPOCH_W'(2 * EPOCHS)) &&
                     ({1'b0, epoch_ff} < 9'(3 * EPOCHS));
   assign avg_due  = {1'b0, epoch_ff} == 9'(3 * EPOCHS);

   // step goes against the gradient; a flat sample or zero step makes the next step positive
   assign reverse = (sample_ff == prev_ff || mag_ff == '0) ? 1'b0 :
                    ((sample_ff > prev_ff) != neg_ff);

   always_comb begin
      pos_in      = pos_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      prev_in     = prev_ff;
      epoch_in    = epoch_ff;
      sum_in      = sum_ff;
      phase_in    = phase_ff;
      rsp_avg_in  = '0;
      rsp_avgv_in = 1'b0;
      if (advance) begin
         case (cmd_ff)
            CMD_START: begin
               epoch_in = '0;
               mag_in   = RATE_W'({sstep_ff, 8'h00});
               neg_in   = 1'b0;
               pos_in   = reduce_span(RED_W'({spos_ff, 8'h00}));
               phase_in = PH_FIRST;
            end
            CMD_MEASURE: begin
               case (phase_ff)
                  PH_FIRST: begin
                     prev_in  = sample_ff;
                     pos_in   = move_position(pos_ff, mag_ff, neg_ff);
                     phase_in = PH_RUN;
                  end
                  PH_RUN: begin
                     if (in_third) begin
                        sum_in = sum_ff + SUM_W'(sample_ff);
                     end else if (avg_due) begin
                        rsp_avg_in  = avg_q;
                        rsp_avgv_in = 1'b1;
                        sum_in      = '0;
                     end
                     mag_in  = rate;
                     neg_in  = reverse;
                     pos_in  = move_position(pos_ff, rate, reverse);
                     prev_in = sample_ff;
                     if (epoch_ff != EPOCH_MAX) begin
                        epoch_in = epoch_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         prev_ff      <= '0;
         epoch_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         prev_ff      <= prev_in;
         epoch_ff     <= epoch_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= command_type'(req_tuser);
         spos_ff   <= req_tdata[10:0];
         sstep_ff  <= req_tdata[15:11];
         sample_ff <= req_tdata[31:16];
      end
      if (advance) begin
         rsp_pos_ff  <= OUT_POS_W'(pos_in);
         rsp_avg_ff  <= rsp_avg_in;
         rsp_avgv_ff <= rsp_avgv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_avg_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_avgv_ff;

   `ASGS_ASSERT_NOW(a_pos_in_span, 32'(pos_ff) < SPAN_Q, "position outside span")
   `ASGS_ASSERT_SAME(a_epoch_only_running, epoch_ff != '0, phase_ff == PH_RUN, "epoch counted outside running phase")
   `ASGS_ASSERT_NEXT(a_sum_cleared, advance && avg_due && cmd_ff == CMD_MEASURE && phase_ff == PH_RUN, sum_ff == '0, "sample sum not cleared after mean")
   `ASGS_ASSERT_SAME(a_hold_ready, req_valid_ff && !advance, !req_tready, "ready raised with a held beat")

endmodule
